// File: rtl/assert_macros.svh
// Assertion macros used by the RTL. Clock and reset are taken from the
// scope of the using module (clk, rst_n).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SBSH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define SBSH_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/sbsh_pkg.sv
`timescale 1ns / 1ps

package sbsh_pkg;

    localparam int unsigned BLOCK_W = 512;
    localparam int unsigned HASH_W  = 256;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Top level to compression core
    typedef struct packed {
        logic start;
        logic init;
    } sbsh_ctl_t;

    // Compression core to top level
    typedef struct packed {
        logic busy;
        logic done;
    } sbsh_sts_t;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] major(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// File: rtl/sbsh_core.sv
`timescale 1ns / 1ps

// One SHA-256 round per cycle over a 16-word schedule window,
// then a feed-forward add into the chaining words.
module sbsh_core
    import sbsh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  sbsh_ctl_t          ctl,
    input  logic [BLOCK_W-1:0] block,
    output sbsh_sts_t          sts,
    output logic [HASH_W-1:0]  hash
);

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ROUND = 3'b010,
        C_ADD   = 3'b100
    } core_state_t;

    core_state_t state_reg, state_next;
    logic [5:0]  round_reg;
    logic [31:0] chain_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];

    logic [31:0] t1, t2, w_new;

    assign t1 = v_reg[7] + bsig1(v_reg[4]) + choose(v_reg[4], v_reg[5], v_reg[6])
              + K_TABLE[round_reg] + w_reg[0];
    assign t2 = bsig0(v_reg[0]) + major(v_reg[0], v_reg[1], v_reg[2]);
    assign w_new = ssig1(w_reg[14]) + w_reg[9] + ssig0(w_reg[1]) + w_reg[0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = C_ADD;
                end
            end
            C_ADD:   state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= H_INIT[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                C_IDLE:
                begin
                    round_reg <= '0;
                    if (ctl.init)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            chain_reg[i] <= H_INIT[i];
                        end
                    end
                end
                C_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                end
                C_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + v_reg[i];
                    end
                end
                default:
                begin
                    round_reg <= '0;
                end
            endcase
        end
    end

    // Working variables and schedule window: no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && ctl.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= chain_reg[i];
            end
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= block[BLOCK_W-1-32*i -: 32];
            end
        end
        else if (state_reg == C_ROUND)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
    end

    assign sts.busy = (state_reg != C_IDLE);
    assign sts.done = (state_reg == C_ADD);

    assign hash = {chain_reg[0], chain_reg[1], chain_reg[2], chain_reg[3],
                   chain_reg[4], chain_reg[5], chain_reg[6], chain_reg[7]};

endmodule

// File: rtl/sha256_byte_stream_hasher_unit.sv
`timescale 1ns / 1ps

// SHA-256 over a byte stream. Each input transaction carries at most one
// message byte (has_byte) and may close the message (is_last); a transaction
// with has_byte low and is_last high closes an empty message or ends one
// without a trailing byte. Bytes are taken at one per cycle while in_stall is
// low. The transaction that completes a 64-byte block stalls the input while
// the shared round unit compresses it (launch, 64 rounds, feed-forward add).
// On is_last the block is padded one byte per cycle up to the next 64-byte
// boundary (0x80, zeros, 64-bit big-endian bit length), needing one or two
// compressions before the first digest word is offered. The digest leaves as
// four output transactions of 64 bits, most significant first, last_word
// marking the fourth. The input is stalled from is_last until the fourth
// output transaction is taken; the hasher then returns to its reset state.
// The bit length wraps modulo 2^64.
module sha256_byte_stream_hasher_unit
    import sbsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,   // taking message bytes
        S_PAD  = 4'b0010,   // shifting padding bytes in
        S_COMP = 4'b0100,   // round unit busy on a block
        S_OUT  = 4'b1000    // presenting digest words
    } top_state_t;

    top_state_t        state_reg, state_next;
    logic [BLOCK_W-1:0] blk_reg;        // byte shift line, first byte ends up on top
    logic [5:0]        fill_reg;        // position in current block
    logic [60:0]       cnt_reg;         // message byte count
    logic [63:0]       len_reg;         // bit length, shifted out top byte first
    logic              pad_first_reg;   // next pad byte is the 0x80 marker
    logic              spill_reg;       // marker landed inside the length field
    logic              final_reg;       // block in flight carries the length
    logic              last_pend_reg;   // is_last seen, padding still to do
    logic              start_reg;
    logic [1:0]        idx_reg;

    logic              in_fire, out_fire;
    logic              blk_full;
    logic              len_byte;
    logic [7:0]        pad_byte;
    logic [60:0]       cnt_after;
    logic [HASH_W-1:0] hash;
    sbsh_ctl_t         core_ctl;
    sbsh_sts_t         core_sts;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid && !out_stall;

    assign blk_full  = has_byte && (fill_reg == LAST_POS);
    assign cnt_after = has_byte ? (cnt_reg + 61'd1) : cnt_reg;

    // Length bytes fill positions 56..63 of the block that holds no spilled marker
    assign len_byte = !pad_first_reg && !spill_reg && (fill_reg >= LEN_POS);
    assign pad_byte = pad_first_reg ? PAD_MARK : (len_byte ? len_reg[63:56] : 8'h00);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (blk_full)
                    begin
                        state_next = S_COMP;
                    end
                    else if (is_last)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                if (fill_reg == LAST_POS)
                begin
                    state_next = S_COMP;
                end
            end
            S_COMP:
            begin
                if (core_sts.done)
                begin
                    if (final_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else if (last_pend_reg)
                    begin
                        state_next = S_PAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT:
            begin
                if (out_fire && last_word)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            pad_first_reg <= 1'b0;
            spill_reg     <= 1'b0;
            final_reg     <= 1'b0;
            last_pend_reg <= 1'b0;
            start_reg     <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        last_pend_reg <= is_last;
                        pad_first_reg <= is_last;
                        spill_reg     <= 1'b0;
                        final_reg     <= 1'b0;
                        cnt_reg       <= cnt_after;
                        if (has_byte)
                        begin
                            fill_reg <= fill_reg + 6'd1;
                        end
                        if (blk_full)
                        begin
                            start_reg <= 1'b1;
                        end
                    end
                end
                S_PAD:
                begin
                    fill_reg      <= fill_reg + 6'd1;
                    pad_first_reg <= 1'b0;
                    if (fill_reg == LAST_POS)
                    begin
                        start_reg <= 1'b1;
                        final_reg <= !pad_first_reg && !spill_reg;
                        spill_reg <= 1'b0;
                    end
                    else if (pad_first_reg)
                    begin
                        spill_reg <= (fill_reg >= LEN_POS);
                    end
                end
                S_COMP:
                begin
                    // start is a one-cycle pulse on entry
                    start_reg <= 1'b0;
                    idx_reg   <= '0;
                end
                S_OUT:
                begin
                    if (out_fire)
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        if (last_word)
                        begin
                            fill_reg      <= '0;
                            cnt_reg       <= '0;
                            final_reg     <= 1'b0;
                            last_pend_reg <= 1'b0;
                            pad_first_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    start_reg <= 1'b0;
                end
            endcase
        end
    end

    // Data path: block shift line and length shifter
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            if (in_fire && has_byte)
            begin
                blk_reg <= {blk_reg[BLOCK_W-9:0], data_byte};
            end
            if (in_fire && is_last)
            begin
                len_reg <= {cnt_after, 3'b000};
            end
        end
        else if (state_reg == S_PAD)
        begin
            blk_reg <= {blk_reg[BLOCK_W-9:0], pad_byte};
            if (len_byte)
            begin
                len_reg <= {len_reg[55:0], 8'h00};
            end
        end
    end

    assign core_ctl.start = start_reg;
    assign core_ctl.init  = out_fire && last_word;

    sbsh_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (core_ctl),
        .block (blk_reg),
        .sts   (core_sts),
        .hash  (hash)
    );

    // Quarter k is chaining words 2k and 2k+1; ~idx picks it from the top
    assign digest_word = hash[{~idx_reg, 6'd0} +: 64];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 2'd3);

    `SBSH_ASSERT_IMP(a_out_blocks_in, out_valid, in_stall)
    `SBSH_ASSERT_IMP(a_core_in_comp, core_sts.busy || start_reg, state_reg == S_COMP)
    `SBSH_ASSERT_NXT(a_clear_after_digest, out_fire && last_word,
                     cnt_reg == '0 && fill_reg == '0 && !core_sts.busy)

endmodule
